### rtl/dalf_pkg.sv
// shared types, constants and register codes for the decimating filter
`timescale 1ns / 1ps
`default_nettype none
package dalf_pkg;
   localparam int AXES       = 3;
   localparam int OUT_AXES   = 3;
   localparam int COUNT_BITS = 16;
   localparam int SUM_BITS   = 32;
   localparam int DIV_STEPS  = SUM_BITS;

   // register indexes
   localparam logic [1:0] REG_PRESCALE = 2'd0;
   localparam logic [1:0] REG_PERIOD   = 2'd1;
   localparam logic [1:0] REG_MAXPER   = 2'd2;
   localparam logic [1:0] REG_ALWAYS   = 2'd3;

   localparam logic [3:0]  PRESCALE_RST = 4'd8;
   localparam logic [31:0] MAXPER_RST   = 32'd1953;
   localparam logic [31:0] PERSIST_STEP = 32'd1000;

   // decimated job handed from front to back
   typedef struct packed {
      logic signed [AXES-1:0][SUM_BITS-1:0] sum;
      logic [COUNT_BITS-1:0]                count;
   } job_type;

   typedef struct packed {
      logic [3:0] prescale;
   } cfg_type;
endpackage
`default_nettype wire

### rtl/dalf_front.sv
// front end: sums samples, counts them and gates decimation on the tick
`timescale 1ns / 1ps
`default_nettype none
module dalf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [15:0]         in_x,
   input  wire logic [15:0]         in_y,
   input  wire logic [15:0]         in_z,
   input  wire logic [31:0]         in_tick,
   input  wire logic [31:0]         out_period,
   input  wire logic [31:0]         max_period,
   input  wire logic                calc_always,
   output logic                     job_valid,
   input  wire logic                job_ready,
   output dalf_pkg::job_type        job
);
   import dalf_pkg::*;

   logic signed [AXES-1:0][SUM_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0] ptick_ff, ptick_in;
   logic job_valid_ff, job_valid_in;
   job_type job_ff, job_in;
   logic [AXES-1:0][15:0] samp;
   logic signed [AXES-1:0][SUM_BITS-1:0] nsum;
   logic [COUNT_BITS-1:0] ncount;
   logic [31:0] diff, period;
   logic [32:0] period2;
   logic fire, accept;

   assign samp[0] = in_x;
   assign samp[1] = in_y;
   assign samp[2] = in_z;

   // one-deep job queue: accept while the slot is free or draining
   assign in_ready = !job_valid_ff || job_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < AXES; i++)
         nsum[i] = sum_ff[i] + {{(SUM_BITS-16){samp[i][15]}}, samp[i]};
      ncount = count_ff + 1'b1;
      diff = in_tick - ptick_ff;
      period = ((out_period == '0) || (out_period > max_period)) ? max_period : out_period;
      period2 = {period, 1'b0};
      fire = calc_always || (diff >= period);
   end

   // accumulate and hand off
   always_comb begin
      sum_in = sum_ff;
      count_in = count_ff;
      ptick_in = ptick_ff;
      job_in = job_ff;
      job_valid_in = job_valid_ff && !job_ready;
      if (accept) begin
         if (fire) begin
            job_in.sum = nsum;
            job_in.count = ncount;
            job_valid_in = 1'b1;
            sum_in = '0;
            count_in = '0;
            ptick_in = ({1'b0, diff} > period2) ? in_tick : ptick_ff + period;
         end else begin
            sum_in = nsum;
            count_in = ncount;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
         ptick_ff <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         ptick_ff <= ptick_in;
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job = job_ff;
endmodule
`default_nettype wire

### rtl/dalf_back.sv
// back end: serial divide for averages, then adaptive filter update
`timescale 1ns / 1ps
`default_nettype none
module dalf_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   output logic                                      job_ready,
   input  wire dalf_pkg::job_type                    job,
   input  wire dalf_pkg::cfg_type                    cfg,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic [dalf_pkg::OUT_AXES-1:0][15:0]       out_avg,
   output logic [dalf_pkg::OUT_AXES-1:0][31:0]       out_filt,
   output logic [2:0]                                out_shift
);
   import dalf_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_PERS  = 3'd2;
   localparam logic [2:0] ST_MAG   = 3'd3;
   localparam logic [2:0] ST_FILT  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [5:0] step_ff, step_in;
   job_type job_ff, job_in;
   // restoring divider on magnitudes
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [32:0] trial;
   logic signed [AXES-1:0][15:0] avg_ff, avg_in;
   logic signed [AXES-1:0][31:0] pers_ff, pers_in, filt_ff, filt_in;
   logic [2:0] shift_ff, shift_in;
   // magnitude / 1000 via repeated subtract count, capped at 8
   logic [31:0] mag_ff, mag_in;
   logic [3:0] mq_ff, mq_in;
   logic out_valid_ff, out_valid_in;
   logic [OUT_AXES-1:0][15:0] oavg_ff, oavg_in;
   logic [OUT_AXES-1:0][31:0] ofilt_ff, ofilt_in;
   logic [2:0] oshift_ff, oshift_in;

   logic signed [31:0] cur_sum;
   logic sum_neg;
   logic [31:0] sum_mag;
   logic signed [32:0] qsigned;
   logic signed [15:0] qsat;
   logic signed [47:0] target, dval, psum, fnew;
   logic signed [31:0] pnext;
   logic signed [31:0] pers_cur, filt_cur;
   logic signed [15:0] avg_cur;
   logic [3:0] mcand;

   assign cur_sum = job_ff.sum[axis_ff];
   assign sum_neg = cur_sum[31];
   assign sum_mag = sum_neg ? 32'(-cur_sum) : cur_sum;
   assign trial = {rem_ff, quo_ff[31]} - {17'd0, job_ff.count};

   always_comb begin
      qsigned = sum_neg ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (job_ff.count == '0) qsat = '0;
      else if (qsigned > 33'sd32767) qsat = 16'sh7fff;
      else if (qsigned < -33'sd32768) qsat = -16'sh8000;
      else qsat = qsigned[15:0];
      avg_cur = avg_ff[axis_ff];
      pers_cur = pers_ff[axis_ff];
      filt_cur = filt_ff[axis_ff];
      target = 48'(avg_cur) <<< cfg.prescale;
      dval = target - 48'(filt_cur);
      psum = 48'(pers_cur) + dval;
      if (((dval < 0) && (pers_cur > 0)) || ((dval > 0) && (pers_cur < 0)))
         pnext = '0;
      else if (psum > 48'sh7fffffff) pnext = 32'sh7fffffff;
      else if (psum < -48'sh80000000) pnext = 32'sh80000000;
      else pnext = psum[31:0];
      mcand = 4'd8 - mq_ff;
      fnew = 48'(filt_cur) + (target >>> shift_ff) - (48'(filt_cur) >>> shift_ff);
   end

   assign job_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff; axis_in = axis_ff; step_in = step_ff; job_in = job_ff;
      quo_in = quo_ff; rem_in = rem_ff; avg_in = avg_ff; pers_in = pers_ff;
      filt_in = filt_ff; shift_in = shift_ff; mag_in = mag_ff; mq_in = mq_ff;
      out_valid_in = out_valid_ff && !out_ready;
      oavg_in = oavg_ff; ofilt_in = ofilt_ff; oshift_in = oshift_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in = job; axis_in = '0; step_in = '0;
               rem_in = '0; state_in = ST_DIV; shift_in = 3'd7;
               quo_in = '0;
            end
         end
         ST_DIV: begin
            // load dividend on step zero, then one quotient bit per cycle
            if (step_ff == '0) begin
               quo_in = sum_mag; rem_in = '0; step_in = 6'd1;
            end else begin
               if (!trial[32]) begin
                  rem_in = trial[31:0];
                  quo_in = {quo_ff[30:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[30:0], quo_ff[31]};
                  quo_in = {quo_ff[30:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == 6'(DIV_STEPS + 1)) begin
                  quo_in = quo_ff;
                  avg_in[axis_ff] = qsat;
                  step_in = '0;
                  if (axis_ff == 2'(AXES-1)) begin
                     axis_in = '0; state_in = ST_PERS;
                  end else axis_in = axis_ff + 1'b1;
               end
            end
         end
         ST_PERS: begin
            pers_in[axis_ff] = pnext;
            mag_in = pnext[31] ? 32'(-pnext) : pnext;
            mq_in = '0;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            if (mq_ff != 4'd8 && mag_ff >= PERSIST_STEP) begin
               mag_in = mag_ff - PERSIST_STEP; mq_in = mq_ff + 1'b1;
            end else begin
               if ({1'b0, mcand} < {1'b0, shift_ff}) shift_in = mcand[2:0];
               if (axis_ff == 2'(AXES-1)) begin
                  axis_in = '0; state_in = ST_FILT;
               end else begin
                  axis_in = axis_ff + 1'b1; state_in = ST_PERS;
               end
            end
         end
         ST_FILT: begin
            if (fnew > 48'sh7fffffff) filt_in[axis_ff] = 32'sh7fffffff;
            else if (fnew < -48'sh80000000) filt_in[axis_ff] = 32'sh80000000;
            else filt_in[axis_ff] = fnew[31:0];
            if (axis_ff == 2'(AXES-1)) begin
               axis_in = '0; state_in = ST_OUT;
            end else axis_in = axis_ff + 1'b1;
         end
         ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               for (int i = 0; i < OUT_AXES; i++) begin
                  oavg_in[i] = (i < AXES) ? avg_ff[i] : '0;
                  ofilt_in[i] = (i < AXES) ? filt_ff[i] : '0;
               end
               oshift_in = shift_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         pers_ff <= '0;
         filt_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         pers_ff <= pers_in;
         filt_ff <= filt_in;
      end
      axis_ff <= axis_in; step_ff <= step_in; job_ff <= job_in;
      quo_ff <= quo_in; rem_ff <= rem_in; avg_ff <= avg_in;
      shift_ff <= shift_in; mag_ff <= mag_in; mq_ff <= mq_in;
      oavg_ff <= oavg_in; ofilt_ff <= ofilt_in; oshift_ff <= oshift_in;
   end

   assign out_valid = out_valid_ff;
   assign out_avg = oavg_ff;
   assign out_filt = ofilt_ff;
   assign out_shift = oshift_ff;
endmodule
`default_nettype wire

### rtl/decimating_adaptive_lowpass_filter_unit.sv
// Decimating adaptive low-pass filter, top level.
// req_ carries one three-axis sample with its tick; rsp_ carries the averages,
// filtered values and smoothing shift of one decimation. Registers are written
// through the csr_ APB-style port; the user must write them only while the
// block is idle, as the block itself does not enforce this. A sample is taken
// by the front end, which sums, counts and checks the period. A decimation
// moves through a one-entry queue to the back end: a shared restoring divider
// for each axis, persistence update and a magnitude scan by repeated
// subtraction for each axis, then filter update for each axis. Samples that do
// not decimate are taken every cycle while the queue has room.
// Reset clears sums, count, period tick, persistence and filter state and
// restores register defaults. A stalled receiver holds rsp_ in its register;
// the back end waits, then the queue fills and req_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module decimating_adaptive_lowpass_filter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // sample_x[15:0], sample_y[31:16], sample_z[47:32], tick_now[79:48]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // avg_x, avg_y, avg_z (16 each), filt_x, filt_y, filt_z (32 each), shift[146:144]
   output logic [151:0]     rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dalf_pkg::*;

   logic [3:0] prescale_ff;
   logic [31:0] period_ff, maxper_ff;
   logic always_ff_r_ff;
   logic wr;
   logic [1:0] ridx;
   logic job_valid, job_ready;
   job_type job;
   cfg_type cfg;
   logic [OUT_AXES-1:0][15:0] avg;
   logic [OUT_AXES-1:0][31:0] filt;
   logic [2:0] shift;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign ridx = csr_paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RST;
         period_ff <= '0;
         maxper_ff <= MAXPER_RST;
         always_ff_r_ff <= 1'b0;
      end else if (wr) begin
         case (ridx)
            REG_PRESCALE: prescale_ff <= csr_pwdata[3:0];
            REG_PERIOD:   period_ff <= csr_pwdata;
            REG_MAXPER:   maxper_ff <= csr_pwdata;
            REG_ALWAYS:   always_ff_r_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (ridx)
         REG_PRESCALE: csr_prdata = {28'd0, prescale_ff};
         REG_PERIOD:   csr_prdata = period_ff;
         REG_MAXPER:   csr_prdata = maxper_ff;
         REG_ALWAYS:   csr_prdata = {31'd0, always_ff_r_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.prescale = prescale_ff;

   dalf_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_x(req_tdata[15:0]), .in_y(req_tdata[31:16]), .in_z(req_tdata[47:32]),
      .in_tick(req_tdata[79:48]),
      .out_period(period_ff), .max_period(maxper_ff), .calc_always(always_ff_r_ff),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   dalf_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job), .cfg(cfg),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_avg(avg), .out_filt(filt), .out_shift(shift)
   );

   assign rsp_tdata = {5'd0, shift, filt[2], filt[1], filt[0], avg[2], avg[1], avg[0]};
endmodule
`default_nettype wire
